[design/bhrb_pkg.sv]
`timescale 1ns / 1ps
`default_nettype none

package bhrb_pkg;

   localparam int DEPTH        = 256;
   localparam int BURST_MAX    = 16;
   localparam int HANDLE_WIDTH = 32;

   // fixed field widths
   localparam int HANDLE_W = 32;
   localparam int COUNT_W  = 5;
   localparam int SIZE_W   = 9;
   localparam int LEFT_W   = 9;
   localparam int STATUS_W = 2;

   // packed stream widths
   localparam int REQ_DATA_W = ((HANDLE_W + COUNT_W + 7) / 8) * 8;
   localparam int RSP_DATA_W = ((HANDLE_W + LEFT_W + 7) / 8) * 8;
   localparam int RSP_USER_W = 1 + STATUS_W;

   // derived storage widths
   localparam int ADDR_W = $clog2(DEPTH);
   localparam int OCC_W  = $clog2(DEPTH + 1);
   localparam int BCNT_W = $clog2(BURST_MAX + 1);
   localparam int CMP_W  = (OCC_W > SIZE_W) ? OCC_W : SIZE_W;
   localparam int MIN_W  = OCC_W + BCNT_W + COUNT_W;

   localparam logic MODE_PUSH = 1'b0;
   localparam logic MODE_GET  = 1'b1;

   localparam logic [STATUS_W-1:0] ST_OK    = 2'd0;
   localparam logic [STATUS_W-1:0] ST_EMPTY = 2'd1;
   localparam logic [STATUS_W-1:0] ST_FULL  = 2'd2;

   typedef enum logic {
      S_IDLE,
      S_BURST
   } state_type;

   typedef struct packed {
      logic push;     // push item accepted
      logic empty;    // get item accepted, nothing to hand out
      logic start;    // get item accepted, burst begins
      logic issue;    // read next slot
      logic consume;  // move read data into the output register
   } cmd_type;

   typedef struct packed {
      logic get_zero;   // clamped burst size of the offered item is zero
      logic rsp_busy;   // output register holds a result
      logic pend;       // read data waiting at the RAM output
      logic pend_last;  // that data is the final handle of the burst
      logic issue_nz;   // reads still to issue
   } sts_type;

endpackage

`default_nettype wire

[design/bhrb_ram.sv]
`timescale 1ns / 1ps
`default_nettype none

module bhrb_ram #(
   parameter int RAM_WIDTH = 32,
   parameter int RAM_DEPTH = 256
) (
   input  wire logic                         clock,
   input  wire logic                         wr_en,
   input  wire logic [$clog2(RAM_DEPTH)-1:0] wr_addr,
   input  wire logic [RAM_WIDTH-1:0]         wr_data,
   input  wire logic                         rd_en,
   input  wire logic [$clog2(RAM_DEPTH)-1:0] rd_addr,
   output logic      [RAM_WIDTH-1:0]         rd_data
);

   logic [RAM_WIDTH-1:0] mem [RAM_DEPTH];

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data <= mem[rd_addr];
      end
   end

endmodule

`default_nettype wire

[design/bhrb_ctrl.sv]
`timescale 1ns / 1ps
`default_nettype none

module bhrb_ctrl
   import bhrb_pkg::*;
(
   input  wire logic    clock,
   input  wire logic    reset,
   input  wire logic    req_tvalid,
   input  wire logic    req_mode,
   output logic         req_tready,
   input  wire logic    rsp_tready,
   input  wire sts_type sts,
   output cmd_type      cmd
);

   state_type state_ff, state_in;
   logic      out_free;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   always_comb begin
      out_free   = !sts.rsp_busy || rsp_tready;
      state_in   = state_ff;
      req_tready = 1'b0;
      cmd        = '0;
      case (state_ff)
         S_IDLE: begin
            req_tready = out_free;
            if (req_tvalid && out_free) begin
               if (req_mode == MODE_PUSH) begin
                  cmd.push = 1'b1;
               end else if (sts.get_zero) begin
                  cmd.empty = 1'b1;
               end else begin
                  cmd.start = 1'b1;
                  state_in  = S_BURST;
               end
            end
         end
         S_BURST: begin
            cmd.consume = sts.pend && out_free;
            cmd.issue   = sts.issue_nz && (!sts.pend || out_free);
            if (cmd.consume && sts.pend_last) begin
               state_in = S_IDLE;
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

endmodule

`default_nettype wire

[design/bhrb_dp.sv]
`timescale 1ns / 1ps
`default_nettype none

module bhrb_dp
   import bhrb_pkg::*;
(
   input  wire logic                  clock,
   input  wire logic                  reset,
   input  wire logic [HANDLE_W-1:0]   req_handle,
   input  wire logic [COUNT_W-1:0]    req_count,
   input  wire logic                  csr_valid,
   input  wire logic [SIZE_W-1:0]     csr_data,
   input  wire logic                  rsp_tready,
   input  wire cmd_type               cmd,
   output sts_type                    sts,
   output logic                       rsp_valid,
   output logic [HANDLE_W-1:0]        rsp_handle,
   output logic                       rsp_hvalid,
   output logic                       rsp_last,
   output logic [LEFT_W-1:0]          rsp_left,
   output logic [STATUS_W-1:0]        rsp_status
);

   logic [ADDR_W-1:0]       rd_pos_ff, rd_pos_in;
   logic [ADDR_W-1:0]       wr_pos_ff, wr_pos_in;
   logic [OCC_W-1:0]        occ_ff, occ_in;
   logic [OCC_W-1:0]        size_ff, size_in;
   logic [BCNT_W-1:0]       left_ff, left_in;
   logic                    pend_ff, pend_in;
   logic                    pend_last_ff, pend_last_in;
   logic                    rsp_valid_ff, rsp_valid_in;
   logic [HANDLE_W-1:0]     rsp_handle_ff, rsp_handle_in;
   logic                    rsp_hvalid_ff, rsp_hvalid_in;
   logic                    rsp_last_ff, rsp_last_in;
   logic [LEFT_W-1:0]       rsp_left_ff, rsp_left_in;
   logic [STATUS_W-1:0]     rsp_status_ff, rsp_status_in;

   logic                    full;
   logic                    push_we;
   logic [MIN_W-1:0]        n_wide;
   logic [BCNT_W-1:0]       burst_n;
   logic [CMP_W-1:0]        csr_wide;
   logic [OCC_W-1:0]        wr_next, rd_next;
   logic [HANDLE_WIDTH-1:0] rd_data;

   bhrb_ram #(
      .RAM_WIDTH (HANDLE_WIDTH),
      .RAM_DEPTH (DEPTH)
   ) u_ram (
      .clock   (clock),
      .wr_en   (push_we),
      .wr_addr (wr_pos_ff),
      .wr_data (HANDLE_WIDTH'(req_handle)),
      .rd_en   (cmd.issue),
      .rd_addr (rd_pos_ff),
      .rd_data (rd_data)
   );

   always_ff @(posedge clock) begin
      if (reset) begin
         rd_pos_ff    <= '0;
         wr_pos_ff    <= '0;
         occ_ff       <= '0;
         size_ff      <= OCC_W'(DEPTH);
         left_ff      <= '0;
         pend_ff      <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         rd_pos_ff    <= rd_pos_in;
         wr_pos_ff    <= wr_pos_in;
         occ_ff       <= occ_in;
         size_ff      <= size_in;
         left_ff      <= left_in;
         pend_ff      <= pend_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      pend_last_ff  <= pend_last_in;
      rsp_handle_ff <= rsp_handle_in;
      rsp_hvalid_ff <= rsp_hvalid_in;
      rsp_last_ff   <= rsp_last_in;
      rsp_left_ff   <= rsp_left_in;
      rsp_status_ff <= rsp_status_in;
   end

   always_comb begin
      full    = occ_ff >= size_ff;
      push_we = cmd.push && !full;

      // burst size: request clamped to the burst limit, then to occupancy
      n_wide = MIN_W'(req_count);
      if (n_wide > MIN_W'(BURST_MAX)) begin
         n_wide = MIN_W'(BURST_MAX);
      end
      if (n_wide > MIN_W'(occ_ff)) begin
         n_wide = MIN_W'(occ_ff);
      end
      burst_n = BCNT_W'(n_wide);

      wr_next = OCC_W'(wr_pos_ff) + OCC_W'(1);
      rd_next = OCC_W'(rd_pos_ff) + OCC_W'(1);

      rd_pos_in    = rd_pos_ff;
      wr_pos_in    = wr_pos_ff;
      occ_in       = occ_ff;
      size_in      = size_ff;
      left_in      = left_ff;
      pend_in      = pend_ff;
      pend_last_in = pend_last_ff;

      // ring size write, only honoured while empty
      csr_wide = CMP_W'(csr_data);
      if (csr_valid && occ_ff == '0) begin
         if (csr_wide == '0) begin
            size_in = OCC_W'(1);
         end else if (csr_wide > CMP_W'(DEPTH)) begin
            size_in = OCC_W'(DEPTH);
         end else begin
            size_in = OCC_W'(csr_wide);
         end
         rd_pos_in = '0;
         wr_pos_in = '0;
      end

      if (push_we) begin
         wr_pos_in = (wr_next >= size_ff) ? '0 : ADDR_W'(wr_next);
         occ_in    = occ_ff + OCC_W'(1);
      end

      if (cmd.start) begin
         left_in = burst_n;
         occ_in  = occ_ff - OCC_W'(n_wide);
      end

      if (cmd.consume) begin
         pend_in = 1'b0;
      end
      if (cmd.issue) begin
         rd_pos_in    = (rd_next >= size_ff) ? '0 : ADDR_W'(rd_next);
         left_in      = left_ff - BCNT_W'(1);
         pend_in      = 1'b1;
         pend_last_in = left_ff == BCNT_W'(1);
      end

      rsp_valid_in  = rsp_valid_ff && !rsp_tready;
      rsp_handle_in = rsp_handle_ff;
      rsp_hvalid_in = rsp_hvalid_ff;
      rsp_last_in   = rsp_last_ff;
      rsp_left_in   = rsp_left_ff;
      rsp_status_in = rsp_status_ff;
      if (cmd.push) begin
         rsp_valid_in  = 1'b1;
         rsp_handle_in = '0;
         rsp_hvalid_in = 1'b0;
         rsp_last_in   = 1'b1;
         rsp_left_in   = full ? LEFT_W'(occ_ff) : LEFT_W'(occ_ff + OCC_W'(1));
         rsp_status_in = full ? ST_FULL : ST_OK;
      end else if (cmd.empty) begin
         rsp_valid_in  = 1'b1;
         rsp_handle_in = '0;
         rsp_hvalid_in = 1'b0;
         rsp_last_in   = 1'b1;
         rsp_left_in   = LEFT_W'(occ_ff);
         rsp_status_in = ST_EMPTY;
      end else if (cmd.consume) begin
         rsp_valid_in  = 1'b1;
         rsp_handle_in = HANDLE_W'(rd_data);
         rsp_hvalid_in = 1'b1;
         rsp_last_in   = pend_last_ff;
         rsp_left_in   = LEFT_W'(occ_ff);
         rsp_status_in = ST_OK;
      end
   end

   always_comb begin
      sts.get_zero  = burst_n == '0;
      sts.rsp_busy  = rsp_valid_ff;
      sts.pend      = pend_ff;
      sts.pend_last = pend_last_ff;
      sts.issue_nz  = left_ff != '0;
   end

   assign rsp_valid  = rsp_valid_ff;
   assign rsp_handle = rsp_handle_ff;
   assign rsp_hvalid = rsp_hvalid_ff;
   assign rsp_last   = rsp_last_ff;
   assign rsp_left   = rsp_left_ff;
   assign rsp_status = rsp_status_ff;

endmodule

`default_nettype wire

[design/buffer_handle_ring_burst_core.sv]
`timescale 1ns / 1ps
`default_nettype none

// channel  direction  transfer when           carries
// req      in         req_tvalid&req_tready   tuser: mode; tdata: handle, count
// rsp      out        rsp_tvalid&rsp_tready   tuser: handle_valid, status;
//                                             tdata: out_handle, entries_left; tlast
// csr      in         csr_valid&csr_ready     ring_size (csr_ready always high)
//
// A push or an empty get is answered from the output register; the next item may follow
// at once unless rsp stalls. A get of n handles is accepted, the first slot is read from
// RAM, then one handle a cycle comes off the read port (while rsp is not stalled), which
// serves the whole burst; the next item can be taken after the last handle is loaded.
// Synchronous active-high reset clears positions and occupancy, sets ring size to DEPTH;
// the slot RAM needs no clearing. A stalled rsp holds the output register and pauses RAM
// reads once read data waits; req is refused while a burst runs.

module buffer_handle_ring_burst_core
   import bhrb_pkg::*;
(
   input  wire logic                  clock,
   input  wire logic                  reset,
   // request stream
   input  wire logic                  req_tvalid,
   output logic                       req_tready,
   input  wire logic [REQ_DATA_W-1:0] req_tdata,   // handle[31:0], count[36:32], zero pad
   input  wire logic                  req_tuser,   // mode
   // response stream
   output logic                       rsp_tvalid,
   input  wire logic                  rsp_tready,
   output logic [RSP_DATA_W-1:0]      rsp_tdata,   // out_handle[31:0], entries_left[40:32], pad
   output logic [RSP_USER_W-1:0]      rsp_tuser,   // handle_valid[0], status[2:1]
   output logic                       rsp_tlast,
   // ring size register
   input  wire logic                  csr_valid,
   output logic                       csr_ready,
   input  wire logic [SIZE_W-1:0]     csr_data
);

   cmd_type               cmd;
   sts_type               sts;
   logic [HANDLE_W-1:0]   rsp_handle;
   logic                  rsp_hvalid;
   logic [LEFT_W-1:0]     rsp_left;
   logic [STATUS_W-1:0]   rsp_status;

   // register writes are taken in any cycle; the datapath ignores them while
   // the ring holds entries
   assign csr_ready = 1'b1;

   bhrb_ctrl u_ctrl (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_mode   (req_tuser),
      .req_tready (req_tready),
      .rsp_tready (rsp_tready),
      .sts        (sts),
      .cmd        (cmd)
   );

   bhrb_dp u_dp (
      .clock      (clock),
      .reset      (reset),
      .req_handle (req_tdata[HANDLE_W-1:0]),
      .req_count  (req_tdata[HANDLE_W+COUNT_W-1:HANDLE_W]),
      .csr_valid  (csr_valid),
      .csr_data   (csr_data),
      .rsp_tready (rsp_tready),
      .cmd        (cmd),
      .sts        (sts),
      .rsp_valid  (rsp_tvalid),
      .rsp_handle (rsp_handle),
      .rsp_hvalid (rsp_hvalid),
      .rsp_last   (rsp_tlast),
      .rsp_left   (rsp_left),
      .rsp_status (rsp_status)
   );

   // pack response fields, lowest first
   assign rsp_tdata = RSP_DATA_W'({rsp_left, rsp_handle});
   assign rsp_tuser = {rsp_status, rsp_hvalid};

endmodule

`default_nettype wire

[design/bhrb_checker.sv]
`timescale 1ns / 1ps
`default_nettype none

module bhrb_checker
   import bhrb_pkg::*;
(
   input wire logic                  clock,
   input wire logic                  reset,
   input wire logic                  req_tready,
   input wire logic                  rsp_tvalid,
   input wire logic                  rsp_tready,
   input wire logic [RSP_DATA_W-1:0] rsp_tdata,
   input wire logic [RSP_USER_W-1:0] rsp_tuser,
   input wire logic                  rsp_tlast
);

   // a stalled response holds
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && !rsp_tready |=> rsp_tvalid && $stable(rsp_tdata)
         && $stable(rsp_tuser) && $stable(rsp_tlast))
      else $error("rsp changed while stalled");

   // a dequeued handle always reports ok
   a_handle_ok: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && rsp_tuser[0] |-> rsp_tuser[2:1] == ST_OK)
      else $error("dequeued handle with bad status");

   // push and empty results are single, with a zero handle
   a_single: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && !rsp_tuser[0] |-> rsp_tlast && rsp_tdata[HANDLE_W-1:0] == '0)
      else $error("non-dequeue result malformed");

   // no new request taken while a burst is still going out
   a_burst_excl: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && rsp_tuser[0] && !rsp_tlast |-> !req_tready)
      else $error("request taken mid-burst");

endmodule

bind buffer_handle_ring_burst_core bhrb_checker u_bhrb_checker (.*);

`default_nettype wire
